// ===== hw/rtl/chb_pkg.sv =====
// Shared constants, types and codes for the cubic Hermite basis evaluator.
`default_nettype none
package chb_pkg;
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int DW  = WORD_BITS;
  localparam int CW  = DW + 2;
  localparam int PW  = DW + CW;
  localparam int NW  = 3 * DW + 4;
  localparam int DDW = 3 * DW;
  localparam int RW  = 4 * DW + 3 * FRAC_BITS + 8;
  localparam int LAT_FRONT = 2;
  localparam int LAT_MUL   = 3;
  localparam int LAT_DIV   = DW + 3;

  localparam logic       KIND_PHI    = 1'b0;
  localparam logic       KIND_PSI    = 1'b1;
  localparam logic [1:0] ORD_VALUE   = 2'd0;
  localparam logic [1:0] ORD_FIRST   = 2'd1;
  localparam logic [1:0] ORD_SECOND  = 2'd2;
  localparam logic [1:0] ORD_INVALID = 2'd3;
  localparam logic [1:0] SH_NONE     = 2'd0;
  localparam logic [1:0] SH_ONE      = 2'd1;
  localparam logic [1:0] SH_TWO      = 2'd2;
  localparam logic [1:0] SH_THREE    = 2'd3;

  typedef struct packed {
    logic       err;
    logic       neg;
    logic [1:0] sh;
  } tag_t;

  typedef struct packed {
    logic [DW-1:0] a;
    logic [CW-1:0] b;
    logic [CW-1:0] c;
    logic [DW-1:0] h;
    logic          cube;
    tag_t          tag;
  } front_t;

  typedef struct packed {
    logic [NW-1:0]  n;
    logic [DDW-1:0] d;
    tag_t           tag;
  } quot_t;
endpackage
`default_nettype wire

// ===== hw/rtl/chb_front.sv =====
// Front end: piece selection, knot distances and operand selection.
`default_nettype none
module chb_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic                            in_valid,
  input  wire logic [chb_pkg::DW-1:0]          point,
  input  wire logic [chb_pkg::DW-1:0]          knot_left,
  input  wire logic [chb_pkg::DW-1:0]          knot_centre,
  input  wire logic [chb_pkg::DW-1:0]          knot_right,
  input  wire logic                            basis_kind,
  input  wire logic [1:0]                      deriv_order,
  output logic                                 out_valid,
  output chb_pkg::front_t                      out_op
);
  import chb_pkg::*;

  logic signed [DW-1:0] px, kl, kc, kr;
  logic err, leftp, rightp, ctr, zero;
  logic [DW-1:0] nr, fr, hd;

  logic          v1_r, v2_r;
  logic [DW-1:0] nr_r, fr_r, h_r;
  logic          kind_r, err_r, zero_r, ctr_r, right_r;
  logic [1:0]    ord_r;
  front_t        op_r, op_nxt;

  logic [DW:0]   fr2, nr2, t1, t2;
  logic [DW-1:0] t3;
  logic [CW-1:0] c2;
  logic          ng1, ng2, ng3;

  assign px = $signed(point);
  assign kl = $signed(knot_left);
  assign kc = $signed(knot_centre);
  assign kr = $signed(knot_right);

  always_comb begin
    err    = (kl > kc) || (kc > kr);
    leftp  = (kl <= px) && (px < kc);
    rightp = (kc < px) && (px <= kr);
    ctr    = (px == kc) && (((basis_kind == KIND_PHI) && (deriv_order == ORD_VALUE)) ||
                            ((basis_kind == KIND_PSI) && (deriv_order == ORD_FIRST)));
    zero   = err || (deriv_order == ORD_INVALID) || (!leftp && !rightp && !ctr);
    nr     = leftp ? point - knot_left   : knot_right - point;
    fr     = leftp ? knot_centre - point : point - knot_centre;
    hd     = leftp ? knot_centre - knot_left : knot_right - knot_centre;
  end

  always_comb begin
    fr2 = {fr_r, 1'b0};
    nr2 = {nr_r, 1'b0};
    ng3 = fr_r < nr_r;
    t3  = ng3 ? nr_r - fr_r : fr_r - nr_r;
    ng1 = {1'b0, nr_r} < fr2;
    t1  = ng1 ? fr2 - {1'b0, nr_r} : {1'b0, nr_r} - fr2;
    ng2 = nr2 < {1'b0, fr_r};
    t2  = ng2 ? {1'b0, fr_r} - nr2 : nr2 - {1'b0, fr_r};
    c2  = {1'b0, fr2} + {2'b00, h_r};

    op_nxt.a    = nr_r;
    op_nxt.b    = {2'b00, nr_r};
    op_nxt.c    = CW'(1);
    op_nxt.h    = h_r;
    op_nxt.cube = (kind_r == KIND_PHI);
    op_nxt.tag  = '{err: err_r, neg: 1'b0, sh: SH_NONE};
    priority if (zero_r) begin
      op_nxt.a    = '0;
      op_nxt.b    = '0;
      op_nxt.c    = '0;
      op_nxt.h    = DW'(1);
      op_nxt.cube = 1'b0;
    end else if (ctr_r) begin
      op_nxt.a    = DW'(1);
      op_nxt.b    = CW'(1);
      op_nxt.h    = DW'(1);
      op_nxt.cube = 1'b0;
      op_nxt.tag.sh = SH_ONE;
    end else begin
      unique case ({kind_r, ord_r})
        {KIND_PHI, ORD_VALUE}: begin
          op_nxt.c      = c2;
          op_nxt.tag.sh = SH_ONE;
        end
        {KIND_PHI, ORD_FIRST}: begin
          op_nxt.b       = {2'b00, fr_r};
          op_nxt.c       = CW'(6);
          op_nxt.tag.neg = right_r;
          op_nxt.tag.sh  = SH_TWO;
        end
        {KIND_PHI, ORD_SECOND}: begin
          op_nxt.a       = t3;
          op_nxt.b       = CW'(1);
          op_nxt.c       = CW'(6);
          op_nxt.tag.neg = ng3;
          op_nxt.tag.sh  = SH_THREE;
        end
        {KIND_PSI, ORD_VALUE}: begin
          op_nxt.c       = {2'b00, fr_r};
          op_nxt.tag.neg = !right_r;
        end
        {KIND_PSI, ORD_FIRST}: begin
          op_nxt.b       = {1'b0, t1};
          op_nxt.tag.neg = ng1;
          op_nxt.tag.sh  = SH_ONE;
        end
        {KIND_PSI, ORD_SECOND}: begin
          op_nxt.a       = DW'(1);
          op_nxt.b       = {1'b0, t2};
          op_nxt.c       = CW'(2);
          op_nxt.tag.neg = ng2 != right_r;
          op_nxt.tag.sh  = SH_TWO;
        end
        default: begin
          op_nxt.a = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    if (en) begin
      nr_r    <= nr;
      fr_r    <= fr;
      h_r     <= hd;
      kind_r  <= basis_kind;
      ord_r   <= deriv_order;
      err_r   <= err;
      zero_r  <= zero;
      ctr_r   <= ctr;
      right_r <= rightp;
      op_r    <= op_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_op    = op_r;
endmodule
`default_nettype wire

// ===== hw/rtl/chb_mul.sv =====
// Multiplier stages: numerator and denominator products.
`default_nettype none
module chb_mul (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire chb_pkg::front_t in_op,
  output logic                 out_valid,
  output chb_pkg::quot_t       out_q
);
  import chb_pkg::*;

  logic [2:0]       v_r;
  logic [PW-1:0]    p_r;
  logic [2*DW-1:0]  hh_r;
  logic [DW-1:0]    hm_r;
  logic [CW-1:0]    c_r;
  tag_t             t3_r, t4_r;
  logic [DW+CW-1:0] plo_r;
  logic [2*CW-1:0]  phi_r;
  logic [2*DW-1:0]  dlo_r, dhi_r;
  quot_t            q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
    if (en) begin
      p_r   <= in_op.a * in_op.b;
      hh_r  <= in_op.h * in_op.h;
      hm_r  <= in_op.cube ? in_op.h : DW'(1);
      c_r   <= in_op.c;
      t3_r  <= in_op.tag;
      plo_r <= p_r[DW-1:0] * c_r;
      phi_r <= p_r[PW-1:DW] * c_r;
      dlo_r <= hh_r[DW-1:0] * hm_r;
      dhi_r <= hh_r[2*DW-1:DW] * hm_r;
      t4_r  <= t3_r;
      q_r.n   <= NW'(plo_r) + (NW'(phi_r) << DW);
      q_r.d   <= DDW'(dlo_r) + (DDW'(dhi_r) << DW);
      q_r.tag <= t4_r;
    end
  end

  assign out_valid = v_r[2];
  assign out_q     = q_r;
endmodule
`default_nettype wire

// ===== hw/rtl/chb_div.sv =====
// Rounding divider: one quotient bit per stage, then saturation and sign.
`default_nettype none
module chb_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire chb_pkg::quot_t         in_q,
  output logic                        out_valid,
  output logic [chb_pkg::DW-1:0]      basis_value,
  output logic                        order_error,
  output logic                        saturated
);
  import chb_pkg::*;

  logic [NW+3*FRAC_BITS-1:0] sn;
  logic          vm_r;
  logic [RW-1:0] m_r, em_r;
  tag_t          tm_r;

  logic          v_r   [0:DW];
  logic [RW-1:0] rem_r [0:DW];
  logic [RW-1:0] e_r   [0:DW];
  logic [DW-1:0] q_r   [0:DW];
  logic          ovf_r [0:DW];
  tag_t          tag_r [0:DW];

  logic          vo_r;
  logic [DW-1:0] val_r;
  logic          err_r, sat_r;

  logic [RW-1:0] sub  [1:DW];
  logic          take [1:DW];
  logic [DW-1:0] lim, mag;
  logic          clip;

  always_comb begin
    unique case (in_q.tag.sh)
      SH_NONE:  sn = (NW+3*FRAC_BITS)'(in_q.n);
      SH_ONE:   sn = (NW+3*FRAC_BITS)'(in_q.n) << FRAC_BITS;
      SH_TWO:   sn = (NW+3*FRAC_BITS)'(in_q.n) << (2 * FRAC_BITS);
      SH_THREE: sn = (NW+3*FRAC_BITS)'(in_q.n) << (3 * FRAC_BITS);
      default:  sn = '0;
    endcase
  end

  always_comb begin
    for (int i = 1; i <= DW; i++) begin
      sub[i]  = e_r[i-1] << (DW - i);
      take[i] = !ovf_r[i-1] && (rem_r[i-1] >= sub[i]);
    end
    lim  = {1'b0, {(DW-1){1'b1}}} + DW'(tag_r[DW].neg);
    clip = ovf_r[DW] || (q_r[DW] > lim);
    mag  = clip ? lim : q_r[DW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      for (int i = 0; i <= DW; i++) v_r[i] <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      vm_r <= in_valid;
      v_r[0] <= vm_r;
      for (int i = 1; i <= DW; i++) v_r[i] <= v_r[i-1];
      vo_r <= v_r[DW];
    end
    if (en) begin
      m_r  <= (RW'(sn) << 1) + RW'(in_q.d);
      em_r <= RW'(in_q.d) << 1;
      tm_r <= in_q.tag;
      rem_r[0] <= m_r;
      e_r[0]   <= em_r;
      q_r[0]   <= '0;
      ovf_r[0] <= m_r >= (em_r << DW);
      tag_r[0] <= tm_r;
      for (int i = 1; i <= DW; i++) begin
        rem_r[i] <= take[i] ? rem_r[i-1] - sub[i] : rem_r[i-1];
        e_r[i]   <= e_r[i-1];
        q_r[i]   <= q_r[i-1] | (DW'(take[i]) << (DW - i));
        ovf_r[i] <= ovf_r[i-1];
        tag_r[i] <= tag_r[i-1];
      end
      val_r <= tag_r[DW].neg ? DW'(0) - mag : mag;
      err_r <= tag_r[DW].err;
      sat_r <= clip;
    end
  end

  assign out_valid   = vo_r;
  assign basis_value = val_r;
  assign order_error = err_r;
  assign saturated   = sat_r;
endmodule
`default_nettype wire

// ===== hw/rtl/cubic_hermite_basis_eval_top.sv =====
// Top level of the cubic Hermite basis evaluator.
// Takes one word per cycle unless the pipeline holds, and returns one result word per input
// word, in order, through two front stages for piece selection and operand setup, three
// multiplier stages, and 35 divider stages: operand setup, the overflow check, one restoring
// stage per quotient bit of the exactly rounded result, and the output register. The whole
// pipeline holds while a finished result waits at the output and moves again once it is taken.
`default_nettype none
module cubic_hermite_basis_eval_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // point, knot_left, knot_centre, knot_right
  input  wire logic [2:0]   in_tuser,   // basis_kind, deriv_order
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata,  // basis_value
  output logic [1:0]        out_tuser   // order_error, saturated
);
  import chb_pkg::*;

  logic   en;
  logic   f_valid, m_valid;
  front_t f_op;
  quot_t  m_q;
  logic   err_o, sat_o;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  chb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_tvalid),
    .point       (in_tdata[DW-1:0]),
    .knot_left   (in_tdata[2*DW-1:DW]),
    .knot_centre (in_tdata[3*DW-1:2*DW]),
    .knot_right  (in_tdata[4*DW-1:3*DW]),
    .basis_kind  (in_tuser[0]),
    .deriv_order (in_tuser[2:1]),
    .out_valid   (f_valid),
    .out_op      (f_op)
  );

  chb_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_op     (f_op),
    .out_valid (m_valid),
    .out_q     (m_q)
  );

  chb_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (m_valid),
    .in_q        (m_q),
    .out_valid   (out_tvalid),
    .basis_value (out_tdata),
    .order_error (err_o),
    .saturated   (sat_o)
  );

  assign out_tuser = {sat_o, err_o};

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && err_o |-> out_tdata == '0 && !sat_o)
    else $error("order error with nonzero result");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && sat_o |-> out_tdata == 32'h7fff_ffff || out_tdata == 32'h8000_0000)
    else $error("saturated result not at range limit");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking stream testbench for the cubic Hermite basis evaluator top level.
module testbench;
  import chb_pkg::*;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] l;
    logic signed [31:0] c;
    logic signed [31:0] r;
    logic               kind;
    logic [1:0]         ord;
  } basis_item_t;

  typedef struct {
    logic [31:0] val;
    logic        err;
    logic        sat;
  } basis_res_t;

  localparam int CYCLE_LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // point, knot_left, knot_centre, knot_right
  logic [2:0]   in_tuser = '0;   // basis_kind, deriv_order
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;       // basis_value
  logic [1:0]   out_tuser;       // order_error, saturated

  basis_item_t pending_words[$];
  basis_res_t  results_due[$];
  basis_item_t cur_word;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          results_seen = 0;
  int          fail_count = 0;
  int          cycles = 0;

  cubic_hermite_basis_eval_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  function automatic basis_res_t eval_basis(basis_item_t it);
    logic [255:0] nr, fr, h, n, d, t, q, lim;
    logic         neg, lp, rp;
    int           s;
    basis_res_t   rr;
    rr.val = '0;
    rr.err = 1'b0;
    rr.sat = 1'b0;
    if (it.l > it.c || it.c > it.r) begin
      rr.err = 1'b1;
      return rr;
    end
    if (it.ord == ORD_INVALID) return rr;
    lp = (it.l <= it.x) && (it.x < it.c);
    rp = (it.c < it.x) && (it.x <= it.r);
    neg = 1'b0;
    s = 0;
    n = 0;
    d = 1;
    if (lp || rp) begin
      if (lp) begin
        nr = longint'(it.x) - longint'(it.l);
        fr = longint'(it.c) - longint'(it.x);
        h  = longint'(it.c) - longint'(it.l);
      end else begin
        nr = longint'(it.r) - longint'(it.x);
        fr = longint'(it.x) - longint'(it.c);
        h  = longint'(it.r) - longint'(it.c);
      end
      if (it.kind == KIND_PHI) begin
        d = h * h * h;
        case (it.ord)
          ORD_VALUE: begin
            n = nr * nr * (2 * fr + h);
            s = FRAC_BITS;
          end
          ORD_FIRST: begin
            n = 6 * nr * fr;
            neg = rp;
            s = 2 * FRAC_BITS;
          end
          default: begin
            if (fr >= nr) n = 6 * (fr - nr);
            else n = 6 * (nr - fr);
            neg = (fr < nr);
            s = 3 * FRAC_BITS;
          end
        endcase
      end else begin
        d = h * h;
        case (it.ord)
          ORD_VALUE: begin
            n = nr * nr * fr;
            neg = lp;
            s = 0;
          end
          ORD_FIRST: begin
            if (nr >= 2 * fr) t = nr - 2 * fr;
            else t = 2 * fr - nr;
            n = nr * t;
            neg = (nr < 2 * fr);
            s = FRAC_BITS;
          end
          default: begin
            if (2 * nr >= fr) t = 2 * nr - fr;
            else t = fr - 2 * nr;
            n = 2 * t;
            neg = (2 * nr < fr) ^ rp;
            s = 2 * FRAC_BITS;
          end
        endcase
      end
    end else if (it.x == it.c && ((it.kind == KIND_PHI && it.ord == ORD_VALUE) ||
                                  (it.kind == KIND_PSI && it.ord == ORD_FIRST))) begin
      n = 1;
      s = FRAC_BITS;
    end else begin
      return rr;
    end
    n = n << s;
    q = (2 * n + d) / (2 * d);
    lim = neg ? (256'(1) << 31) : ((256'(1) << 31) - 1);
    if (q > lim) begin
      q = lim;
      rr.sat = 1'b1;
    end
    rr.val = neg ? -q[31:0] : q[31:0];
    return rr;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint pick_span();
    case ($urandom_range(0, 3))
      0: return longint'($urandom_range(1, 16));
      1: return longint'($urandom_range(1, 65536 * 4));
      2: return longint'($urandom >> $urandom_range(0, 31));
      default: return 0;
    endcase
  endfunction

  function automatic basis_item_t gen_word();
    basis_item_t it;
    longint      lo, hi;
    logic [63:0] span;
    int          mode;
    mode = $urandom_range(0, 99);
    it.kind = $urandom_range(0, 1);
    it.ord = $urandom_range(0, 3);
    it.c = $urandom;
    if ($urandom_range(0, 3) == 0) it.c = $signed($urandom_range(0, 65536 * 8)) - 32'sd262144;
    it.l = clamp32(longint'(it.c) - pick_span());
    it.r = clamp32(longint'(it.c) + pick_span());
    lo = it.l;
    hi = it.r;
    if (mode < 60) begin
      span = hi - lo + 1;
      it.x = lo + longint'({$urandom, $urandom} % span);
    end else if (mode < 72) begin
      it.x = it.c;
    end else if (mode < 82) begin
      case ($urandom_range(0, 3))
        0: it.x = it.l;
        1: it.x = it.r;
        2: it.x = clamp32(lo - 1);
        default: it.x = clamp32(hi + 1);
      endcase
    end else begin
      it.x = $urandom;
      it.l = $urandom;
      it.c = $urandom;
      it.r = $urandom;
    end
    return it;
  endfunction

  function automatic basis_item_t mk(int x, int l, int c, int r, logic kind, logic [1:0] ord);
    basis_item_t it;
    it.x = x;
    it.l = l;
    it.c = c;
    it.r = r;
    it.kind = kind;
    it.ord = ord;
    return it;
  endfunction

  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_tvalid || results_due.size() != 0);
  endtask

  // Driver: present words from the pending queue, predict each as it is taken.
  always @(posedge clk) begin
    basis_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) results_due.push_back(eval_basis(cur_word));
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        it = pending_words.pop_front();
        cur_word <= it;
        in_tdata <= {it.r, it.c, it.l, it.x};
        in_tuser <= {it.ord, it.kind};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Hold off the receiver once for a long stretch.
  always @(posedge clk) begin
    if (rst_n) begin
      if (results_seen >= 100 && !hold_done) begin
        hold_left <= 300;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Monitor: check results in order and drive back-pressure.
  always @(posedge clk) begin
    basis_res_t ex;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t unexpected word: value %h err %b sat %b", $time,
                   out_tdata, out_tuser[0], out_tuser[1]);
          fail_count++;
        end else begin
          ex = results_due.pop_front();
          if (out_tdata !== ex.val || out_tuser[0] !== ex.err || out_tuser[1] !== ex.sat) begin
            $display("%0t mismatch: expected value %h err %b sat %b, got value %h err %b sat %b",
                     $time, ex.val, ex.err, ex.sat, out_tdata, out_tuser[0], out_tuser[1]);
            fail_count++;
          end
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int ph;
    int idle_tab[4];
    int stall_tab[4];
    idle_tab = '{0, 83, 0, 27};
    stall_tab = '{0, 0, 83, 27};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    pending_words.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                               KIND_PHI, ORD_VALUE));
    pending_words.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               KIND_PSI, ORD_FIRST));
    pending_words.push_back(mk(0, 10, 5, 20, KIND_PHI, ORD_VALUE));
    pending_words.push_back(mk(0, -10, 5, 2, KIND_PSI, ORD_SECOND));
    pending_words.push_back(mk(0, -65536, 0, 65536, KIND_PHI, ORD_INVALID));
    pending_words.push_back(mk(0, 0, 0, 65536, KIND_PSI, ORD_VALUE));
    pending_words.push_back(mk(65536, 0, 65536, 65536, KIND_PHI, ORD_VALUE));
    pending_words.push_back(mk(5, -65536, 0, 65536, KIND_PHI, ORD_SECOND));
    pending_words.push_back(mk(-1, -1, 0, 1, KIND_PHI, ORD_SECOND));
    pending_words.push_back(mk(1, -1, 0, 1, KIND_PSI, ORD_SECOND));
    pending_words.push_back(mk(32'h80000000, 32'h80000000, 0, 32'h7fffffff, KIND_PHI, ORD_VALUE));
    pending_words.push_back(mk(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, KIND_PSI, ORD_FIRST));
    pending_words.push_back(mk(-100, -65536, 0, 65536, KIND_PSI, ORD_VALUE));
    for (int k = 0; k < 2; k++) begin
      for (int o = 0; o < 3; o++) begin
        pending_words.push_back(mk(-32768, -65536, 0, 65536, k, o));
        pending_words.push_back(mk(32768, -65536, 0, 65536, k, o));
      end
    end
    drain();
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      for (int i = 0; i < 425; i++) pending_words.push_back(gen_word());
      drain();
    end
    repeat (60) @(posedge clk);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
